@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the expander top. They compile to
// nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked assertion that is disabled while reset is active.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Clocked assertion that is checked during reset too.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/core/bmpx_pkg.sv @@
// ----------------------------------------------------------------------------
// bmpx_pkg
// Types, constants and color packing for the 4bpp palette expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmpx_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned TABLE_AW      = 4;
  localparam int unsigned COLOR_W       = 16;
  localparam int unsigned WIDTH_W       = 9;
  localparam int unsigned CMP_W         = WIDTH_W + 2;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 9'd320;
  localparam logic [WIDTH_W-1:0] WIDTH_LIMIT = 9'd511;

  // Input beat layout.
  localparam int unsigned IN_DATA_W    = 40;
  localparam int unsigned IDX_LSB      = 0;
  localparam int unsigned BLUE_LSB     = 4;
  localparam int unsigned GREEN_LSB    = 12;
  localparam int unsigned RED_LSB      = 20;
  localparam int unsigned PIXEL_LSB    = 28;

  // Configuration port.
  localparam int unsigned ADDR_W       = 3;
  localparam int unsigned REG_SEL_BIT  = 2;
  localparam logic        REG_IMAGE_WIDTH = 1'b0;

  typedef enum logic {
    MODE_PALETTE = 1'b0,
    MODE_PIXEL   = 1'b1
  } mode_e;

  typedef struct packed {
    logic                en;
    logic [TABLE_AW-1:0] addr;
    logic [COLOR_W-1:0]  data;
  } wr_req_t;

  typedef struct packed {
    logic                en;
    logic [TABLE_AW-1:0] addr_a;
    logic [TABLE_AW-1:0] addr_b;
  } rd_req_t;

  // Truncate to 5/6/5 bits and store the RGB565 word with its bytes swapped.
  function automatic logic [COLOR_W-1:0] pack_color(input logic [7:0] blue,
                                                    input logic [7:0] green,
                                                    input logic [7:0] red);
    logic [5:0] g6;
    g6 = green[7:2];
    return {g6[2:0], blue[7:3], red[7:3], g6[5:3]};
  endfunction

endpackage

@@ rtl/core/bmpx_color_ram.sv @@
// ----------------------------------------------------------------------------
// bmpx_color_ram
// Palette memory: one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmpx_color_ram (
  input  logic                              clk_i,
  input  bmpx_pkg::wr_req_t                 wr_i,
  input  bmpx_pkg::rd_req_t                 rd_i,
  output logic [bmpx_pkg::COLOR_W-1:0]      rd_a_o,
  output logic [bmpx_pkg::COLOR_W-1:0]      rd_b_o
);
  import bmpx_pkg::*;

  logic [COLOR_W-1:0] mem_q [TABLE_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Read data holds between reads, so it doubles as the output register.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_a_o <= mem_q[rd_i.addr_a];
      rd_b_o <= mem_q[rd_i.addr_b];
    end
  end

endmodule

@@ rtl/core/bmp_4bpp_palette_expander_top.sv @@
// ----------------------------------------------------------------------------
// bmp_4bpp_palette_expander_top
// Expands packed 4bpp bitmap rows into byte-swapped RGB565 pixel words.
// ----------------------------------------------------------------------------
//  Channel   Dir  Beat contents
//  s_axis    in   tuser: mode; tdata: entry_index, blue, green, red, pixel_byte
//  m_axis    out  tdata: color; tlast: end_of_row; tuser: last_of_item
//  APB       in   register 0 at address 0: image_width
//
//  A pixel byte gives one output beat per pixel that lies in the row: two
//  when both pixels lie in it, one when the low pixel is past the row end.
//  Palette loads and row padding bytes give no beat. The first beat is valid
//  the cycle after the accept, straight from the registered read port of the
//  palette memory. Reset clears the row position and sets image_width to 320;
//  the palette is undefined until loaded. While a byte waits in the output
//  stage the input is held off until its final beat leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmp_4bpp_palette_expander_top #(
  parameter int unsigned MAX_WIDTH = 320
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [3:0] entry_index, [11:4] blue, [19:12] green, [27:20] red,
  // [35:28] pixel_byte, [39:36] zero
  input  logic [bmpx_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [0] mode
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [15:0] color
  output logic [bmpx_pkg::COLOR_W-1:0]       m_axis_tdata,
  output logic                               m_axis_tlast,
  // [0] last_of_item
  output logic                               m_axis_tuser,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bmpx_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import bmpx_pkg::*;

  localparam int unsigned EFF_MAX  = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
  localparam int unsigned MAX_LINE = (((EFF_MAX + 1) / 2 + 3) / 4) * 4;
  localparam int unsigned POS_W    = $clog2(MAX_LINE);
  localparam logic [WIDTH_W-1:0] W_MAX = WIDTH_W'(EFF_MAX);

  logic [WIDTH_W-1:0] width_q;
  logic [POS_W-1:0]   pos_q;
  logic               cfg_wr;

  logic               s_fire, m_fire, is_pix, pix_emit_fire, last_beat;
  logic [WIDTH_W-1:0] w_eff;
  logic [CMP_W-1:0]   w_c, data_c, line_c, pos_c, left_c, right_c, pos_inc, pos_nxt;
  logic               emit, has_right, eor_hi, eor_lo;

  logic               s1_valid_q, phase_q, two_q, eor_hi_q, eor_lo_q;

  wr_req_t            wr_req;
  rd_req_t            rd_req;
  logic [COLOR_W-1:0] rd_hi, rd_lo;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready &
                  (paddr[REG_SEL_BIT] == REG_IMAGE_WIDTH);

  always_comb begin
    prdata = '0;
    if (paddr[REG_SEL_BIT] == REG_IMAGE_WIDTH) begin
      prdata = {{(32 - WIDTH_W){1'b0}}, width_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
    end else if (cfg_wr) begin
      width_q <= pwdata[WIDTH_W-1:0];
    end
  end

  // Row geometry for the current beat.
  always_comb begin
    if (width_q == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (width_q > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = width_q;
    end
    w_c       = CMP_W'(w_eff);
    data_c    = (w_c + CMP_W'(1)) >> 1;
    line_c    = (data_c + CMP_W'(3)) & ~CMP_W'(3);
    pos_c     = (CMP_W'(pos_q) >= line_c) ? '0 : CMP_W'(pos_q);
    emit      = pos_c < data_c;
    left_c    = pos_c << 1;
    right_c   = left_c + CMP_W'(1);
    has_right = right_c < w_c;
    eor_hi    = left_c == (w_c - CMP_W'(1));
    eor_lo    = right_c == (w_c - CMP_W'(1));
    pos_inc   = pos_c + CMP_W'(1);
    pos_nxt   = (pos_inc >= line_c) ? '0 : pos_inc;
  end

  // Handshakes. A new item may enter as the final beat of the last one leaves.
  assign last_beat     = phase_q | ~two_q;
  assign s_axis_tready = ~s1_valid_q | (m_axis_tready & last_beat);
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign m_fire        = m_axis_tvalid & m_axis_tready;
  assign is_pix        = (s_axis_tuser == MODE_PIXEL);
  assign pix_emit_fire = s_fire & is_pix & emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cfg_wr) begin
      pos_q <= '0;
    end else if (s_fire && is_pix) begin
      pos_q <= pos_nxt[POS_W-1:0];
    end
  end

  // Palette writes land at the accept edge, so a later pixel byte always
  // reads the new entry and no forwarding path is needed.
  always_comb begin
    wr_req.en     = s_fire & ~is_pix;
    wr_req.addr   = s_axis_tdata[IDX_LSB +: TABLE_AW];
    wr_req.data   = pack_color(s_axis_tdata[BLUE_LSB +: 8],
                               s_axis_tdata[GREEN_LSB +: 8],
                               s_axis_tdata[RED_LSB +: 8]);
    rd_req.en     = pix_emit_fire;
    rd_req.addr_a = s_axis_tdata[PIXEL_LSB + TABLE_AW +: TABLE_AW];
    rd_req.addr_b = s_axis_tdata[PIXEL_LSB +: TABLE_AW];
  end

  bmpx_color_ram u_color_ram (
    .clk_i  (clk_i),
    .wr_i   (wr_req),
    .rd_i   (rd_req),
    .rd_a_o (rd_hi),
    .rd_b_o (rd_lo)
  );

  // Output stage: the high pixel goes out first, then the low pixel if any.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= 1'b0;
      two_q      <= 1'b0;
      eor_hi_q   <= 1'b0;
      eor_lo_q   <= 1'b0;
    end else if (pix_emit_fire) begin
      s1_valid_q <= 1'b1;
      phase_q    <= 1'b0;
      two_q      <= has_right;
      eor_hi_q   <= eor_hi;
      eor_lo_q   <= eor_lo;
    end else if (m_fire) begin
      if (last_beat) begin
        s1_valid_q <= 1'b0;
      end else begin
        phase_q <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = s1_valid_q;
  assign m_axis_tdata  = phase_q ? rd_lo : rd_hi;
  assign m_axis_tlast  = phase_q ? eor_lo_q : eor_hi_q;
  assign m_axis_tuser  = last_beat;

  `ASSERT_RST(a_lo_needs_two, clk_i, rst_ni, (s1_valid_q && phase_q) |-> two_q)
  `ASSERT_RST(a_pos_in_line, clk_i, rst_ni, (CMP_W'(pos_q) < line_c))
  `ASSERT_RST(a_row_end_single, clk_i, rst_ni, (s1_valid_q && eor_hi_q) |-> !two_q)
  `ASSERT_RST(a_second_beat, clk_i, rst_ni,
              (s1_valid_q && !phase_q && two_q && m_fire) |=> (s1_valid_q && phase_q))

endmodule
